>>> hw/rtl/icgr_pkg.sv
package icgr_pkg;

   localparam int SLOTS_DEF    = 16;
   localparam int KEY_BITS_DEF = 16;
   localparam int REF_BITS_DEF = 8;

   localparam int KEY_IN_W    = 16;
   localparam int STATUS_W    = 3;
   localparam int REF_OUT_W   = 8;
   localparam int SLOT_OUT_W  = 4;
   localparam int RSP_DATA_W  = 16;

   localparam logic REQ_GET     = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

endpackage

>>> hw/rtl/icgr_ram.sv
module icgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/inode_cache_get_release_top.sv
// Reference-counted key cache over SLOTS slots with a FIFO of free slot indices.
// A word on req_ carries a key in req_tdata and the operation in req_tuser
// (0 get, 1 release); every request returns exactly one word on rsp_. One
// request is worked at a time: the keys sit in a single-port-read RAM that is
// scanned one slot per cycle, so a scan for a key stops at the slot that holds
// it, and a miss scans every slot before the result register is loaded.
// The result register lets the next request be accepted and scanned while an
// earlier result waits; the block stalls only to load a new result into a full
// register. Slot indices in rsp_tdata are the low 4 bits of the slot number.
module inode_cache_get_release_top #(
   parameter int SLOTS    = icgr_pkg::SLOTS_DEF,
   parameter int KEY_BITS = icgr_pkg::KEY_BITS_DEF,
   parameter int REF_BITS = icgr_pkg::REF_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [icgr_pkg::KEY_IN_W-1:0]   req_tdata,   // [15:0] key
   input  logic                            req_tuser,   // [0] req_type
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [icgr_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [7:0] ref_count, [11:8] slot
   output logic [icgr_pkg::STATUS_W-1:0]   rsp_tuser    // [2:0] status
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int WORD_W = KEY_BITS + REF_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                type_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [SLOT_W:0]     scan_ff, scan_in;
   logic                pend_ff, pend_in;
   logic [SLOT_W-1:0]   pidx_ff, pidx_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   fidx_ff, fidx_in;
   logic [REF_BITS-1:0] frefs_ff, frefs_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [SLOT_W-1:0]   head_ff, head_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic                wrap_ff, wrap_in;
   logic [CNT_W-1:0]    free_cnt_ff, free_cnt_in;
   logic                fifo_init_ff;
   logic [SLOT_W-1:0]   fifo_raddr_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [icgr_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [icgr_pkg::REF_OUT_W-1:0]  rsp_refs_ff, rsp_refs_in;
   logic [icgr_pkg::SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic                slot_we;
   logic [SLOT_W-1:0]   slot_waddr;
   logic [WORD_W-1:0]   slot_wdata;
   logic [SLOT_W-1:0]   slot_raddr;
   logic [WORD_W-1:0]   slot_rdata;

   logic                fifo_we;
   logic [SLOT_W-1:0]   fifo_waddr;
   logic [SLOT_W-1:0]   fifo_wdata;
   logic [SLOT_W-1:0]   fifo_rdata;
   logic [SLOT_W-1:0]   fifo_q;

   logic                req_acc;
   logic                out_free;
   logic [31:0]         key_ext;
   logic                issue;
   logic                hit_now;
   logic                last_cmp;
   logic [REF_BITS-1:0] refs_inc;
   logic [15:0]         refs_ext;
   logic [7:0]          idx_ext;
   logic [SLOT_W-1:0]   head_nxt;
   logic [SLOT_W-1:0]   tail_nxt;

   icgr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   icgr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign key_ext    = 32'(req_tdata);

   // unwritten free-list entries hold their own index
   assign fifo_q = fifo_init_ff ? fifo_rdata : fifo_raddr_ff;

   assign slot_raddr = scan_ff[SLOT_W-1:0];
   assign issue      = (scan_ff < (SLOT_W + 1)'(SLOTS));
   assign hit_now    = pend_ff && valid_ff[pidx_ff] && (slot_rdata[KEY_BITS-1:0] == key_ff);
   assign last_cmp   = pend_ff && (pidx_ff == SLOT_W'(SLOTS - 1));

   assign refs_inc = (frefs_ff == {REF_BITS{1'b1}}) ? frefs_ff : frefs_ff + REF_BITS'(1);
   assign head_nxt = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + SLOT_W'(1);
   assign tail_nxt = (tail_ff == SLOT_W'(SLOTS - 1)) ? '0 : tail_ff + SLOT_W'(1);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      frefs_in      = frefs_ff;
      valid_in      = valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      wrap_in       = wrap_ff;
      free_cnt_in   = free_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_refs_in   = rsp_refs_ff;
      rsp_slot_in   = rsp_slot_ff;
      slot_we       = 1'b0;
      slot_waddr    = fidx_ff;
      slot_wdata    = {refs_inc, key_ff};
      fifo_we       = 1'b0;
      fifo_waddr    = tail_ff;
      fifo_wdata    = fidx_ff;
      refs_ext      = '0;
      idx_ext       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit_now) begin
               found_in = 1'b1;
               fidx_in  = pidx_ff;
               frefs_in = slot_rdata[WORD_W-1:KEY_BITS];
               state_in = S_DONE;
            end else if (last_cmp) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               pend_in = issue;
               pidx_in = scan_ff[SLOT_W-1:0];
               if (issue) begin
                  scan_in = scan_ff + (SLOT_W + 1)'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (type_ff == icgr_pkg::REQ_GET) begin
                  if (found_ff) begin
                     slot_we       = 1'b1;
                     refs_ext      = 16'(refs_inc);
                     idx_ext       = 8'(fidx_ff);
                     rsp_status_in = icgr_pkg::ST_HIT;
                  end else if (free_cnt_ff == '0) begin
                     rsp_status_in = icgr_pkg::ST_FULL;
                  end else begin
                     slot_we             = 1'b1;
                     slot_waddr          = fifo_q;
                     slot_wdata          = {REF_BITS'(1), key_ff};
                     valid_in[fifo_q]    = 1'b1;
                     head_in             = head_nxt;
                     free_cnt_in         = free_cnt_ff - CNT_W'(1);
                     refs_ext            = 16'd1;
                     idx_ext             = 8'(fifo_q);
                     rsp_status_in       = icgr_pkg::ST_NEW;
                  end
               end else begin
                  if (found_ff) begin
                     valid_in[fidx_ff] = 1'b0;
                     if (free_cnt_ff < CNT_W'(SLOTS)) begin
                        fifo_we     = 1'b1;
                        tail_in     = tail_nxt;
                        free_cnt_in = free_cnt_ff + CNT_W'(1);
                        if (tail_ff == SLOT_W'(SLOTS - 1)) begin
                           wrap_in = 1'b1;
                        end
                     end
                     idx_ext       = 8'(fidx_ff);
                     rsp_status_in = icgr_pkg::ST_FREED;
                  end else begin
                     rsp_status_in = icgr_pkg::ST_ABSENT;
                  end
               end
               rsp_refs_in = refs_ext[icgr_pkg::REF_OUT_W-1:0];
               rsp_slot_in = idx_ext[icgr_pkg::SLOT_OUT_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wrap_ff      <= 1'b0;
         free_cnt_ff  <= CNT_W'(SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wrap_ff      <= wrap_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         type_ff <= req_tuser;
         key_ff  <= key_ext[KEY_BITS-1:0];
      end
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      found_ff      <= found_in;
      fidx_ff       <= fidx_in;
      frefs_ff      <= frefs_in;
      fifo_init_ff  <= wrap_ff || (head_ff < tail_ff);
      fifo_raddr_ff <= head_ff;
      rsp_status_ff <= rsp_status_in;
      rsp_refs_ff   <= rsp_refs_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(icgr_pkg::RSP_DATA_W - icgr_pkg::SLOT_OUT_W
                          - icgr_pkg::REF_OUT_W){1'b0}}, rsp_slot_ff, rsp_refs_ff};

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) + int'(free_cnt_ff)) == SLOTS)
      else $error("valid slots plus free slots differ from pool size");

   a_fifo_ends: assert property (@(posedge clock) disable iff (reset)
      (free_cnt_ff == '0 || free_cnt_ff == CNT_W'(SLOTS)) |-> (head_ff == tail_ff))
      else $error("free list pointers disagree with an empty or full list");

   a_live_refs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == icgr_pkg::ST_HIT || rsp_tuser == icgr_pkg::ST_NEW)
       && !$past(rsp_tvalid)) |-> (rsp_refs_ff != '0 || REF_BITS > icgr_pkg::REF_OUT_W))
      else $error("hit or allocation reported a zero reference count");

   a_done_updates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("finished request did not load the result register");

endmodule
